// ===== sv/windowed_affine_fit_on_path_assert.svh =====
// Assertion macros for the windowed affine fit block.
// Expects clk and rst in the scope where the macros are used.
`ifndef WINDOWED_AFFINE_FIT_ON_PATH_ASSERT_SVH
`define WINDOWED_AFFINE_FIT_ON_PATH_ASSERT_SVH

// same-cycle implication
`define WAFP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WAFP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/wafp_pkg.sv =====
// Shared types and constants for the windowed affine fit block.
// No dependencies.
package wafp_pkg;

  localparam int ACC_W      = 48;
  localparam int CNT_W      = 12;
  localparam int SL_W       = 11;
  localparam int HW_W       = 6;
  localparam int HW_LIMIT   = 63;
  localparam int WCNT_W     = 7;
  localparam int WIDE_W     = 64;
  localparam int FRAC_W     = 16;
  localparam int DIV_W      = WIDE_W + FRAC_W;
  localparam int MUL_STEPS  = 48;
  localparam int STEP_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int OFF_SHIFT  = 12;

  localparam logic [CNT_W-1:0] COUNT_MAX = 12'd4095;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C_MIN         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C_MAX         = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WIN, ST_DRAIN, ST_LOAD, ST_RUN, ST_WB, ST_DEC, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_AVG_X, OP_AVG_G, OP_AVG_T, OP_AVG_P,
    OP_NX, OP_TP, OP_NG, OP_TT, OP_SCALE, OP_ST, OP_OFF
  } op_t;

endpackage

// ===== sv/windowed_affine_fit_on_path.sv =====
// A load word leaves busy low. A path point in range reads its window and
// then runs the averaging divides; a last point adds multiply and divide
// steps on the one shift/add-subtract unit. One point at a time (busy high).
// The result strobe done is high for one cycle. rst is synchronous, active
// high; sample stores are not cleared.
module windowed_affine_fit_on_path
  import wafp_pkg::*;
#(
  parameter int MAX_LENGTH     = 1024,
  parameter int MAX_HALF_WIDTH = 32,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [$clog2(MAX_LENGTH)-1:0] sample_index,
  input  logic signed [SAMPLE_BITS-1:0] sample_s,
  input  logic signed [SAMPLE_BITS-1:0] sample_t,
  input  logic [$clog2(MAX_LENGTH)-1:0] path_s_index,
  input  logic [$clog2(MAX_LENGTH)-1:0] path_t_index,
  input  logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic                          done,
  output logic signed [OUT_W-1:0]       scaling,
  output logic signed [OUT_W-1:0]       offset,
  output logic [STATUS_W-1:0]           status
);

  localparam int AW     = $clog2(MAX_LENGTH);
  localparam int LW     = $clog2(MAX_LENGTH + 1);
  localparam int LEN_W  = (LW > SL_W) ? LW : SL_W;
  localparam int PW     = LEN_W + 2;
  localparam int SW     = 2 * SAMPLE_BITS + WCNT_W;
  localparam int HW_CAP = (MAX_HALF_WIDTH > HW_LIMIT) ? HW_LIMIT : MAX_HALF_WIDTH;
  localparam int SH_AVG = DIV_W - SW;

  localparam logic signed [OUT_W-1:0] S32_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] S32_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  function automatic logic [WIDE_W-1:0] abs_w(input logic signed [WIDE_W-1:0] v);
    abs_w = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_mag(input logic big, input logic neg,
                                                      input logic [OUT_W-1:0] m);
    if (big) sat_mag = neg ? S32_MIN : S32_MAX;
    else     sat_mag = neg ? OUT_W'(-m) : OUT_W'(m);
  endfunction

  state_t state, state_next;
  op_t    op, op_next;

  logic [SL_W-1:0]         signal_length;
  logic [HW_W-1:0]         half_width;
  logic signed [OUT_W-1:0] c_min, c_max;

  logic signed [SAMPLE_BITS-1:0] sig_mem [MAX_LENGTH];
  logic signed [SAMPLE_BITS-1:0] ref_mem [MAX_LENGTH];

  logic signed [ACC_W-1:0] cross_sum, ref_square_sum, ref_sum, signal_sum;
  logic [CNT_W-1:0]        point_count;
  logic                    range_error;

  logic [PW-1:0]     pa, pb;
  logic [WCNT_W-1:0] wk, wcnt;
  logic              last_r, v1, v2;
  logic signed [SAMPLE_BITS-1:0]   rd_s, rd_t, pr_s, pr_t;
  logic signed [2*SAMPLE_BITS-1:0] ps_st, ps_tt;
  logic signed [SW-1:0]            sx, sg, st, ss;

  logic [WIDE_W:0]      u_acc;
  logic [DIV_W-1:0]     u_b;
  logic [WIDE_W-1:0]    u_d;
  logic [STEP_W-1:0]    u_k;
  logic                 u_sgn, u_div;
  logic signed [WIDE_W-1:0] p1, num, den;
  logic signed [OUT_W-1:0]  scale_r, offset_r;
  logic [STATUS_W-1:0]      status_r;

  // control decode
  logic accept, pt_accept, ld_accept, pt_bad, in_rng;
  logic win_issue, unit_load, unit_step, unit_wb, dec_en, emit_en;
  logic [LEN_W-1:0]  len_e;
  logic [HW_W-1:0]   hw_e;
  logic [AW:0]       widx;
  logic [AW-1:0]     wa;
  logic [WCNT_W-1:0] wdiv;

  assign len_e = (LEN_W'(signal_length) > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                               : LEN_W'(signal_length);
  assign hw_e  = (half_width > HW_W'(HW_CAP)) ? HW_W'(HW_CAP) : half_width;
  assign accept    = start && !busy;
  assign pt_accept = accept && kind;
  assign ld_accept = accept && !kind;
  assign pt_bad = (LEN_W'(path_s_index) >= len_e) || (LEN_W'(path_t_index) >= len_e) ||
                  (point_count >= COUNT_MAX);
  assign in_rng = !pa[PW-1] && !pb[PW-1] &&
                  (pa[PW-2:0] < (PW-1)'(len_e)) && (pb[PW-2:0] < (PW-1)'(len_e));
  assign widx = {1'b0, sample_index};
  assign wa   = (widx >= (AW+1)'(MAX_LENGTH)) ? AW'(widx - (AW+1)'(MAX_LENGTH))
                                              : sample_index;
  assign wdiv = (wcnt == '0) ? WCNT_W'(1) : wcnt;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      ST_IDLE: begin
        if (pt_accept) begin
          if (!pt_bad) begin
            state_next = ST_WIN;
          end else if (last) begin
            state_next = ST_LOAD;
            op_next    = OP_NX;
          end
        end
      end
      ST_WIN: begin
        if (wk == '0) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_LOAD;
          op_next    = OP_AVG_X;
        end
      end
      ST_LOAD: state_next = ST_RUN;
      ST_RUN: begin
        if (u_k == STEP_W'(1)) state_next = ST_WB;
      end
      ST_WB: begin
        state_next = ST_LOAD;
        unique case (op)
          OP_AVG_X: op_next = OP_AVG_G;
          OP_AVG_G: op_next = OP_AVG_T;
          OP_AVG_T: op_next = OP_AVG_P;
          OP_AVG_P: begin
            if (last_r) op_next = OP_NX;
            else        state_next = ST_IDLE;
          end
          OP_NX:    op_next = OP_TP;
          OP_TP:    op_next = OP_NG;
          OP_NG:    op_next = OP_TT;
          OP_TT:    state_next = ST_DEC;
          OP_SCALE: op_next = OP_ST;
          OP_ST:    op_next = OP_OFF;
          OP_OFF:   state_next = ST_EMIT;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_DEC: begin
        if (den != '0) begin
          state_next = ST_LOAD;
          op_next    = OP_SCALE;
        end else if (point_count == '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_LOAD;
          op_next    = OP_ST;
        end
      end
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    done      = (state == ST_EMIT);
    win_issue = (state == ST_WIN);
    unit_load = (state == ST_LOAD);
    unit_step = (state == ST_RUN);
    unit_wb   = (state == ST_WB);
    dec_en    = (state == ST_DEC);
    emit_en   = (state == ST_EMIT);
  end

  // operand select for the shared unit
  logic signed [SW-1:0]    sum_sel;
  logic [SW-1:0]           sum_mag;
  logic signed [ACC_W-1:0] m_a, m_b;
  logic [WIDE_W-1:0]       a_mag, b_mag;
  logic signed [WIDE_W-1:0] num2;
  logic [DIV_W-1:0]  ld_b;
  logic [WIDE_W-1:0] ld_d;
  logic [STEP_W-1:0] ld_k;
  logic              ld_sgn, ld_div;

  always_comb begin
    case (op)
      OP_AVG_X: sum_sel = sx;
      OP_AVG_G: sum_sel = sg;
      OP_AVG_T: sum_sel = st;
      default:  sum_sel = ss;
    endcase
  end
  assign sum_mag = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);

  always_comb begin
    case (op)
      OP_NX:   begin m_a = cross_sum;      m_b = ACC_W'({1'b0, point_count}); end
      OP_TP:   begin m_a = ref_sum;        m_b = signal_sum; end
      OP_NG:   begin m_a = ref_square_sum; m_b = ACC_W'({1'b0, point_count}); end
      OP_TT:   begin m_a = ref_sum;        m_b = ref_sum; end
      OP_ST:   begin m_a = ref_sum;        m_b = ACC_W'(scale_r); end
      default: begin m_a = '0;             m_b = '0; end
    endcase
  end
  assign a_mag = abs_w(WIDE_W'(m_a));
  assign b_mag = abs_w(WIDE_W'(m_b));
  assign num2  = (WIDE_W'(signal_sum) <<< FRAC_W) - p1;

  always_comb begin
    ld_b = '0; ld_d = '0; ld_k = '0; ld_sgn = 1'b0; ld_div = 1'b0;
    case (op) inside
      OP_AVG_X, OP_AVG_G, OP_AVG_T, OP_AVG_P: begin
        ld_b = DIV_W'(sum_mag) << SH_AVG;
        ld_d = WIDE_W'(wdiv);
        ld_k = STEP_W'(SW);
        ld_sgn = sum_sel[SW-1];
        ld_div = 1'b1;
      end
      OP_NX, OP_TP, OP_NG, OP_TT, OP_ST: begin
        ld_b = DIV_W'(b_mag[MUL_STEPS-1:0]);
        ld_d = a_mag;
        ld_k = STEP_W'(MUL_STEPS);
        ld_sgn = m_a[ACC_W-1] ^ m_b[ACC_W-1];
      end
      OP_SCALE: begin
        ld_b = {abs_w(num), FRAC_W'(0)};
        ld_d = abs_w(den);
        ld_k = STEP_W'(DIV_W);
        ld_sgn = num[WIDE_W-1] ^ den[WIDE_W-1];
        ld_div = 1'b1;
      end
      OP_OFF: begin
        ld_b = {abs_w(num2), FRAC_W'(0)};
        ld_d = WIDE_W'(point_count) << OFF_SHIFT;
        ld_k = STEP_W'(WIDE_W);
        ld_sgn = num2[WIDE_W-1];
        ld_div = 1'b1;
      end
      default: ;
    endcase
  end

  // one step of the shared unit
  logic [WIDE_W:0]   rem_sh;
  logic [WIDE_W+1:0] diff;
  logic              ge;
  logic [WIDE_W-1:0] mul_sum;

  assign rem_sh  = {u_acc[WIDE_W-1:0], u_b[DIV_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b0, u_d};
  assign ge      = !diff[WIDE_W+1];
  assign mul_sum = u_acc[WIDE_W-1:0] + (u_b[0] ? u_d : '0);

  // unit results
  logic signed [WIDE_W-1:0] prod_s, q_s;
  logic signed [OUT_W-1:0]  scale_raw, scale_clamped, off_val;

  assign prod_s = u_sgn ? WIDE_W'(-u_acc[WIDE_W-1:0]) : WIDE_W'(u_acc[WIDE_W-1:0]);
  assign q_s    = u_sgn ? WIDE_W'(-u_b[WIDE_W-1:0]) : WIDE_W'(u_b[WIDE_W-1:0]);
  assign scale_raw = sat_mag(|u_b[DIV_W-1:OUT_W-1], u_sgn, u_b[OUT_W-1:0]);
  assign scale_clamped = (scale_raw < c_min) ? c_min :
                         (scale_raw > c_max) ? c_max : scale_raw;
  assign off_val = sat_mag(|u_b[WIDE_W-1:OUT_W-1], u_sgn, u_b[OUT_W-1:0]);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      op             <= OP_AVG_X;
      signal_length  <= SL_W'(1024);
      half_width     <= '0;
      c_min          <= '0;
      c_max          <= S32_MAX;
      cross_sum      <= '0;
      ref_square_sum <= '0;
      ref_sum        <= '0;
      signal_sum     <= '0;
      point_count    <= '0;
      range_error    <= 1'b0;
      v1             <= 1'b0;
      v2             <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      v1    <= win_issue && in_rng;
      v2    <= v1;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SIGNAL_LENGTH: signal_length <= cfg_data[SL_W-1:0];
          CFG_HALF_WIDTH:    half_width    <= cfg_data[HW_W-1:0];
          CFG_C_MIN:         c_min         <= cfg_data[OUT_W-1:0];
          CFG_C_MAX:         c_max         <= cfg_data[OUT_W-1:0];
        endcase
      end
      if (pt_accept && pt_bad) range_error <= 1'b1;
      if (unit_wb) begin
        case (op)
          OP_AVG_X: cross_sum      <= cross_sum + q_s[ACC_W-1:0];
          OP_AVG_G: ref_square_sum <= ref_square_sum + q_s[ACC_W-1:0];
          OP_AVG_T: ref_sum        <= ref_sum + q_s[ACC_W-1:0];
          OP_AVG_P: begin
            signal_sum  <= signal_sum + q_s[ACC_W-1:0];
            point_count <= point_count + CNT_W'(1);
          end
          default: ;
        endcase
      end
      if (emit_en) begin
        cross_sum      <= '0;
        ref_square_sum <= '0;
        ref_sum        <= '0;
        signal_sum     <= '0;
        point_count    <= '0;
        range_error    <= 1'b0;
      end
    end
  end

  // sample stores
  always_ff @(posedge clk) begin
    if (ld_accept) begin
      sig_mem[wa] <= sample_s;
      ref_mem[wa] <= sample_t;
    end
    rd_s <= sig_mem[pa[AW-1:0]];
    rd_t <= ref_mem[pb[AW-1:0]];
  end

  // window walk and sums
  always_ff @(posedge clk) begin
    ps_st <= rd_s * rd_t;
    ps_tt <= rd_t * rd_t;
    pr_s  <= rd_s;
    pr_t  <= rd_t;
    if (pt_accept) begin
      pa     <= PW'(path_s_index) - PW'(hw_e);
      pb     <= PW'(path_t_index) - PW'(hw_e);
      wk     <= {hw_e, 1'b0};
      last_r <= last;
      wcnt   <= '0;
      sx <= '0; sg <= '0; st <= '0; ss <= '0;
    end else begin
      if (win_issue) begin
        pa <= pa + PW'(1);
        pb <= pb + PW'(1);
        wk <= wk - WCNT_W'(1);
      end
      if (v2) begin
        sx   <= sx + SW'(ps_st);
        sg   <= sg + SW'(ps_tt);
        st   <= st + SW'(pr_t);
        ss   <= ss + SW'(pr_s);
        wcnt <= wcnt + WCNT_W'(1);
      end
    end
  end

  // shared shift/add-subtract unit and final results
  always_ff @(posedge clk) begin
    if (unit_load) begin
      u_acc <= '0;
      u_b   <= ld_b;
      u_d   <= ld_d;
      u_k   <= ld_k;
      u_sgn <= ld_sgn;
      u_div <= ld_div;
    end else if (unit_step) begin
      u_k <= u_k - STEP_W'(1);
      if (u_div) begin
        u_acc <= ge ? diff[WIDE_W:0] : rem_sh;
        u_b   <= {u_b[DIV_W-2:0], ge};
      end else begin
        u_acc <= {1'b0, mul_sum};
        u_d   <= {u_d[WIDE_W-2:0], 1'b0};
        u_b   <= {1'b0, u_b[DIV_W-1:1]};
      end
    end
    if (unit_wb) begin
      case (op)
        OP_NX, OP_NG, OP_ST: p1 <= prod_s;
        OP_TP:    num <= p1 - prod_s;
        OP_TT:    den <= p1 - prod_s;
        OP_SCALE: begin
          scale_r  <= scale_clamped;
          status_r <= range_error ? STATUS_RANGE : STATUS_OK;
        end
        OP_OFF:   offset_r <= off_val;
        default: ;
      endcase
    end
    if (dec_en && den == '0) begin
      scale_r  <= c_max;
      status_r <= range_error ? STATUS_RANGE : STATUS_ZERO_DEN;
      if (point_count == '0) offset_r <= '0;
    end
  end

  assign scaling = scale_r;
  assign offset  = offset_r;
  assign status  = status_r;

endmodule

// ===== sv/wafp_checker.sv =====
// Port-level checks for windowed_affine_fit_on_path, bound to the top level.
// Depends on wafp_pkg and windowed_affine_fit_on_path_assert.svh.
module wafp_checker
  import wafp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                kind,
  input logic                done,
  input logic [STATUS_W-1:0] status
);

`include "windowed_affine_fit_on_path_assert.svh"

  `WAFP_ASSERT_IMP(a_done_busy, done, busy, "result word while idle")
  `WAFP_ASSERT_NXT(a_done_one, done, !done && !busy, "result strobe longer than one cycle")
  `WAFP_ASSERT_IMP(a_status, done, status <= STATUS_RANGE, "bad status")
  `WAFP_ASSERT_NXT(a_load_fast, start && !busy && !kind, !busy, "load word left block busy")

endmodule

bind windowed_affine_fit_on_path wafp_checker u_wafp_checker (.*);

// ===== tb/tb_windowed_affine_fit_on_path.sv =====
// Self-checking testbench for windowed_affine_fit_on_path: loads sample pairs, walks paths,
// predicts scale/offset/status per path and compares every result word.
// Depends on wafp_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_windowed_affine_fit_on_path;
  import wafp_pkg::*;

  localparam int DEPTH = 1024;
  localparam int FILL = 128;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic        kind;
    logic [9:0]  idx;
    logic [15:0] s;
    logic [15:0] t;
    logic [9:0]  ps;
    logic [9:0]  pt;
    logic        last;
    logic        typed;
    logic [31:0] e_scale;
    logic [31:0] e_off;
    logic [1:0]  e_status;
  } vec_t;

  typedef struct packed {
    logic [31:0] scaling;
    logic [31:0] offset;
    logic [1:0]  status;
  } fit_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0, kind = 0, last = 0;
  logic [9:0] sample_index = 0, path_s_index = 0, path_t_index = 0;
  logic signed [15:0] sample_s = 0, sample_t = 0;
  logic cfg_valid = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SIGNAL_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  logic busy, cfg_ready, done;
  logic signed [31:0] scaling, offset;
  logic [1:0] status;

  windowed_affine_fit_on_path dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic signed [15:0] sig_mem [DEPTH];
  logic signed [15:0] ref_mem [DEPTH];
  longint cross_acc, sq_acc, ref_acc, sig_acc;
  int unsigned npoints;
  bit range_err;
  logic [10:0] len_reg;
  logic [5:0] hw_reg;
  logic signed [31:0] cmin_reg, cmax_reg;

  fit_t fit_q [$];
  int errors = 0;
  int paths_done = 0;
  int items_sent = 0;
  int watch = 0;

  function automatic longint unsigned q16_div(longint unsigned num, longint unsigned den);
    longint unsigned q, r, frac;
    q = num / den;
    r = num % den;
    frac = 0;
    if (q > 65536) q = 65536;
    for (int i = 15; i >= 0; i--) begin
      r = r << 1;
      if (r >= den) begin
        r -= den;
        frac |= 64'd1 << i;
      end
    end
    return (q << 16) | frac;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int eff_len();
    return (len_reg > DEPTH) ? DEPTH : int'(len_reg);
  endfunction

  function automatic void clear_path();
    cross_acc = 0; sq_acc = 0; ref_acc = 0; sig_acc = 0;
    npoints = 0; range_err = 0;
  endfunction

  // returns 1 and fills res when the word closes a path
  function automatic bit fit_step(vec_t v, output fit_t res);
    longint len, hw, cnt, sx, sg, st, ss, a, b, vs, vt, n, num, den, sc, off, q;
    res = '0;
    if (!v.kind) begin
      sig_mem[v.idx] = v.s;
      ref_mem[v.idx] = v.t;
      return 0;
    end
    len = eff_len();
    hw = (hw_reg > 32) ? 32 : hw_reg;
    if (v.ps >= len || v.pt >= len || npoints >= 4095) begin
      range_err = 1;
    end else begin
      cnt = 0; sx = 0; sg = 0; st = 0; ss = 0;
      for (longint m = -hw; m <= hw; m++) begin
        a = v.ps + m;
        b = v.pt + m;
        if (a < 0 || b < 0 || a >= len || b >= len) continue;
        vs = sig_mem[a];
        vt = ref_mem[b];
        cnt++;
        sx += vs * vt;
        sg += vt * vt;
        st += vt;
        ss += vs;
      end
      if (cnt == 0) cnt = 1;
      cross_acc += sx / cnt;
      sq_acc += sg / cnt;
      ref_acc += st / cnt;
      sig_acc += ss / cnt;
      npoints++;
    end
    if (!v.last) return 0;
    n = npoints;
    num = n * cross_acc - ref_acc * sig_acc;
    den = n * sq_acc - ref_acc * ref_acc;
    if (den == 0) begin
      sc = cmax_reg;
      res.status = STATUS_ZERO_DEN;
    end else begin
      q = q16_div(num < 0 ? -num : num, den < 0 ? -den : den);
      if ((num < 0) != (den < 0)) q = -q;
      sc = sat32(q);
      if (sc < cmin_reg) sc = cmin_reg;
      else if (sc > cmax_reg) sc = cmax_reg;
      res.status = STATUS_OK;
    end
    if (range_err) res.status = STATUS_RANGE;
    off = (n == 0) ? 0 : sat32((sig_acc * 65536 - sc * ref_acc) / (n * 4096));
    res.scaling = sc[31:0];
    res.offset = off[31:0];
    clear_path();
    return 1;
  endfunction

  // result checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
        $display("%0t timeout, nothing accepted for %0d cycles", $time, WATCH_LIMIT);
        $display("tb: failure");
        $finish;
      end
      if (done) begin
        if (fit_q.size() == 0) begin
          $display("%0t unexpected result %h %h %0d", $time, scaling, offset, status);
          errors++;
        end else begin
          fit_t e;
          e = fit_q.pop_front();
          if (scaling !== e.scaling) begin
            $display("%0t scaling exp %h got %h", $time, e.scaling, scaling);
            errors++;
          end
          if (offset !== e.offset) begin
            $display("%0t offset exp %h got %h", $time, e.offset, offset);
            errors++;
          end
          if (status !== e.status) begin
            $display("%0t status exp %0d got %0d", $time, e.status, status);
            errors++;
          end
          paths_done++;
        end
      end
    end
  end

  // drive one word; start stays high unless a gap follows
  task automatic send_word(vec_t v, int idle_pct);
    fit_t res;
    kind <= v.kind;
    sample_index <= v.idx;
    sample_s <= v.s;
    sample_t <= v.t;
    path_s_index <= v.ps;
    path_t_index <= v.pt;
    last <= v.last;
    start <= 1;
    do @(posedge clk); while (busy);
    items_sent++;
    if (fit_step(v, res)) begin
      if (v.typed) fit_q.push_back({v.e_scale, v.e_off, v.e_status});
      else fit_q.push_back(res);
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (fit_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [10:0] len, logic [5:0] hw,
                            logic signed [31:0] lo, logic signed [31:0] hi);
    logic [31:0] vals [4];
    vals = '{32'(len), 32'(hw), lo, hi};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 0;
    len_reg = len;
    hw_reg = hw;
    cmin_reg = lo;
    cmax_reg = hi;
  endtask

  // path points keep every window inside the loaded part of the stores
  function automatic vec_t rand_word(bit force_last);
    vec_t v;
    int el, hw, lim;
    v = '0;
    el = eff_len();
    hw = (hw_reg > 32) ? 32 : int'(hw_reg);
    lim = (el <= FILL) ? el : FILL - hw;
    v.kind = force_last ? 1'b1 : ($urandom_range(99) >= 40);
    v.idx = 10'($urandom_range(FILL - 1));
    case ($urandom_range(7))
      0: v.s = 16'h8000;
      1: v.s = 16'h7FFF;
      default: v.s = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0: v.t = 16'h8000;
      1: v.t = 16'h7FFF;
      default: v.t = 16'($urandom);
    endcase
    if (lim > 0 && (el == DEPTH || $urandom_range(9) != 0)) begin
      v.ps = 10'($urandom_range(lim - 1));
      v.pt = 10'($urandom_range(lim - 1));
    end else begin
      v.ps = 10'($urandom_range(DEPTH - 1, el));
      v.pt = 10'($urandom_range(DEPTH - 1));
    end
    v.last = force_last ? 1'b1 : ($urandom_range(7) == 0);
    return v;
  endfunction

  vec_t dir_rows [13] = '{
    '{1'b0, 10'd5,    16'h1000, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b1, 10'd0,    16'h0000, 16'h0000, 10'd5, 10'd5, 1'b1, 1'b1,
      32'h7FFFFFFF, 32'h00010000, STATUS_ZERO_DEN},
    '{1'b0, 10'd0,    16'h8000, 16'h8000, 10'd0, 10'd0, 1'b0, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b0, 10'd1023, 16'h7FFF, 16'h7FFF, 10'd0, 10'd0, 1'b0, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b1, 10'd0,    16'h0000, 16'h0000, 10'd0, 10'd1023, 1'b0, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b1, 10'd0,    16'h0000, 16'h0000, 10'd1023, 10'd0, 1'b1, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b0, 10'd7,    16'h0000, 16'h0000, 10'd0, 10'd0, 1'b1, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b1, 10'd0,    16'h0000, 16'h0000, 10'd7, 10'd7, 1'b1, 1'b1,
      32'h7FFFFFFF, 32'h00000000, STATUS_ZERO_DEN},
    '{1'b1, 10'd0,    16'h0000, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b1, 10'd0,    16'h0000, 16'h0000, 10'd1023, 10'd1023, 1'b0, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b1, 10'd0,    16'h0000, 16'h0000, 10'd5, 10'd5, 1'b1, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b0, 10'd3,    16'hFFFF, 16'h0001, 10'd0, 10'd0, 1'b0, 1'b0, 32'h0, 32'h0, 2'd0},
    '{1'b1, 10'd0,    16'h0000, 16'h0000, 10'd3, 10'd1023, 1'b1, 1'b0, 32'h0, 32'h0, 2'd0}
  };

  initial begin
    vec_t v;
    int idle_pct [6] = '{0, 82, 0, 20, 82, 0};
    clear_path();
    len_reg = 11'd1024;
    hw_reg = 0;
    cmin_reg = 0;
    cmax_reg = 32'sh7FFFFFFF;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_regs(11'd1024, 6'd0, 32'sd0, 32'sh7FFFFFFF);

    // fill the low part of both stores; windows stay inside it
    for (int i = 0; i < FILL; i++) begin
      v = rand_word(0);
      v.kind = 0;
      v.idx = 10'(i);
      send_word(v, 0);
    end
    foreach (dir_rows[i]) send_word(dir_rows[i], 0);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_regs(11'd1024, 6'd32, 32'sh80000000, 32'sh7FFFFFFF);
        1: write_regs(11'd16, 6'd63, -32'sd65536, 32'sd65536);
        2: write_regs(11'd0, 6'd5, 32'sd0, 32'sd0);
        3: write_regs(11'd2047, 6'd1, 32'sd131072, -32'sd131072);
        4: write_regs(11'($urandom_range(1, 1024)), 6'($urandom_range(0, 40)),
                      -32'sd200000, 32'sd300000);
        default: write_regs(11'd1, 6'd3, 32'sh7FFFFFFF, 32'sh80000000);
      endcase
      for (int k = 0; k < 84; k++) send_word(rand_word(0), idle_pct[ph]);
      send_word(rand_word(1), idle_pct[ph]);
      settle();
    end
    repeat (50) @(posedge clk);

    $display("covered %0d words, %0d path results, 7 register settings incl. extremes",
             items_sent, paths_done);
    $display("window widths 0..63, lengths 0..2047, sender gaps, %0d errors", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== windowed_affine_fit_on_path.f =====
+incdir+sv
sv/wafp_pkg.sv
sv/windowed_affine_fit_on_path.sv
sv/wafp_checker.sv
tb/tb_windowed_affine_fit_on_path.sv
